// ----- sv/bgfc_pkg.sv -----
// Package for the binary frame checker: codes, reset values and shared types.
`default_nettype none
package bgfc_pkg;

  // Byte position counter width and saturation value
  localparam int unsigned POS_W   = 17;
  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

  // Fixed byte positions inside a frame
  localparam logic [POS_W-1:0] POS_SYNC1  = POS_W'(0);
  localparam logic [POS_W-1:0] POS_SYNC2  = POS_W'(1);
  localparam logic [POS_W-1:0] POS_CLASS  = POS_W'(2);
  localparam logic [POS_W-1:0] POS_ID     = POS_W'(3);
  localparam logic [POS_W-1:0] POS_LEN_LO = POS_W'(4);
  localparam logic [POS_W-1:0] POS_LEN_HI = POS_W'(5);
  // first payload byte; also the header span that the length excludes
  localparam logic [POS_W-1:0] POS_ECHO_CLASS = POS_W'(6);
  localparam logic [POS_W-1:0] POS_ECHO_ID    = POS_W'(7);
  // last summed byte sits at length + LEN_OFFSET
  localparam logic [POS_W-1:0] LEN_OFFSET = POS_W'(5);

  // Register indexes on the config port
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] IDX_EXP_CLASS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] IDX_EXP_MSG_ID = 3'd1;
  localparam logic [CFG_IDX_W-1:0] IDX_ACK_MODE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] IDX_SYNC_FIRST = 3'd3;
  localparam logic [CFG_IDX_W-1:0] IDX_SYNC_SEC   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] IDX_ACK_CLASS  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] IDX_ACK_POS_ID = 3'd6;
  localparam logic [CFG_IDX_W-1:0] IDX_ACK_NEG_ID = 3'd7;

  // Register reset values
  localparam logic [7:0] RST_SYNC_FIRST = 8'd181;
  localparam logic [7:0] RST_SYNC_SEC   = 8'd98;
  localparam logic [7:0] RST_ACK_CLASS  = 8'd5;
  localparam logic [7:0] RST_ACK_POS_ID = 8'd1;
  localparam logic [7:0] RST_ACK_NEG_ID = 8'd0;

  // Frame status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_ERROR   = 2'd2;
  localparam logic [1:0] ST_UNUSED  = 2'd3;

  typedef struct packed {
    logic [7:0] cmd_class;
    logic [7:0] expected_msg_id;
    logic       ack_mode;
    logic [7:0] sync_first;
    logic [7:0] sync_second;
    logic [7:0] ack_class;
    logic [7:0] ack_positive_id;
    logic [7:0] ack_negative_id;
  } cfg_t;

  typedef struct packed {
    logic [1:0] frame_status;
    logic [7:0] sum_a;
    logic [7:0] sum_b;
  } result_t;

endpackage
`default_nettype wire

// ----- sv/bgfc_if.sv -----
// Valid/ready channel interfaces for input bytes and frame results.
`default_nettype none
interface bgfc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       end_of_buffer;

  modport source (output valid, output rx_byte, output end_of_buffer, input ready);
  modport sink   (input valid, input rx_byte, input end_of_buffer, output ready);
endinterface

interface bgfc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] frame_status;
  logic [7:0] sum_a;
  logic [7:0] sum_b;

  modport source (output valid, output frame_status, output sum_a, output sum_b,
                  input ready);
  modport sink   (input valid, input frame_status, input sum_a, input sum_b,
                  output ready);
endinterface
`default_nettype wire

// ----- sv/bgfc_core.sv -----
// Frame state and per-byte checking: header match, length, Fletcher-8 sums, status.
`default_nettype none
module bgfc_core (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire bgfc_pkg::cfg_t   cfg,
  input  wire logic             step,
  input  wire logic [7:0]       rx_byte,
  input  wire logic             last,
  output bgfc_pkg::result_t     result
);

  logic [bgfc_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic [7:0]  sum_a_r, sum_a_nxt;
  logic [7:0]  sum_b_r, sum_b_nxt;
  logic [15:0] len_r, len_nxt;
  logic        hdr_good_r, hdr_good_nxt;
  logic [7:0]  id_r, id_nxt;
  logic        echo_good_r, echo_good_nxt;
  logic [7:0]  prev_byte_r;

  logic [7:0]  want_cls, want_id;
  logic [bgfc_pkg::POS_W-1:0] sum_end;
  logic        sum_it, frame_valid;
  logic [1:0]  status;

  // Header, length and echo capture for the current byte
  always_comb begin
    want_cls = cfg.ack_mode ? cfg.ack_class : cfg.cmd_class;
    want_id  = cfg.ack_mode ? cfg.ack_positive_id : cfg.expected_msg_id;

    hdr_good_nxt  = hdr_good_r;
    id_nxt        = id_r;
    len_nxt       = len_r;
    echo_good_nxt = echo_good_r;
    if (pos_r == bgfc_pkg::POS_SYNC1) hdr_good_nxt = hdr_good_r && (rx_byte == cfg.sync_first);
    if (pos_r == bgfc_pkg::POS_SYNC2) hdr_good_nxt = hdr_good_r && (rx_byte == cfg.sync_second);
    if (pos_r == bgfc_pkg::POS_CLASS) hdr_good_nxt = hdr_good_r && (rx_byte == want_cls);
    if (pos_r == bgfc_pkg::POS_ID) begin
      id_nxt       = rx_byte;
      hdr_good_nxt = hdr_good_r && (rx_byte == want_id);
    end
    if (pos_r == bgfc_pkg::POS_LEN_LO) len_nxt = {len_r[15:8], rx_byte};
    if (pos_r == bgfc_pkg::POS_LEN_HI) len_nxt = {rx_byte, len_r[7:0]};
    if (pos_r == bgfc_pkg::POS_ECHO_CLASS)
      echo_good_nxt = echo_good_r && (rx_byte == cfg.cmd_class);
    if (pos_r == bgfc_pkg::POS_ECHO_ID)
      echo_good_nxt = echo_good_r && (rx_byte == cfg.expected_msg_id);
  end

  // Fletcher-8 over class .. end of payload
  always_comb begin
    sum_end = {1'b0, len_nxt} + bgfc_pkg::LEN_OFFSET;
    if (pos_r >= bgfc_pkg::POS_CLASS && pos_r < bgfc_pkg::POS_ECHO_CLASS) begin
      sum_it = 1'b1;
    end else if (pos_r >= bgfc_pkg::POS_ECHO_CLASS) begin
      sum_it = (pos_r <= sum_end);
    end else begin
      sum_it = 1'b0;
    end
    sum_a_nxt = sum_it ? sum_a_r + rx_byte : sum_a_r;
    sum_b_nxt = sum_it ? sum_b_r + sum_a_nxt : sum_b_r;
    pos_nxt   = (pos_r != bgfc_pkg::POS_MAX) ? pos_r + 1'b1 : pos_r;
  end

  // Verdict; buffer size is pos_r + 1, so size >= n becomes pos_r >= n - 1
  always_comb begin
    frame_valid = (pos_r >= bgfc_pkg::POS_ECHO_ID) && hdr_good_nxt &&
                  (pos_r >= sum_end) &&
                  (sum_a_nxt == prev_byte_r) && (sum_b_nxt == rx_byte);
    if (!cfg.ack_mode) begin
      status = frame_valid ? bgfc_pkg::ST_OK : bgfc_pkg::ST_INVALID;
    end else if (frame_valid) begin
      status = echo_good_nxt ? bgfc_pkg::ST_OK : bgfc_pkg::ST_ERROR;
    end else if (pos_r >= bgfc_pkg::POS_ID && id_nxt == cfg.ack_negative_id) begin
      status = bgfc_pkg::ST_ERROR;
    end else begin
      status = bgfc_pkg::ST_INVALID;
    end
    result.frame_status = status;
    result.sum_a        = sum_a_nxt;
    result.sum_b        = sum_b_nxt;
  end

  // Frame state: advance per byte, clear after the last byte
  always_ff @(posedge clk) begin
    if (!rst_n || (step && last)) begin
      pos_r       <= '0;
      sum_a_r     <= '0;
      sum_b_r     <= '0;
      len_r       <= '0;
      hdr_good_r  <= 1'b1;
      id_r        <= '0;
      echo_good_r <= 1'b1;
      prev_byte_r <= '0;
    end else if (step) begin
      pos_r       <= pos_nxt;
      sum_a_r     <= sum_a_nxt;
      sum_b_r     <= sum_b_nxt;
      len_r       <= len_nxt;
      hdr_good_r  <= hdr_good_nxt;
      id_r        <= id_nxt;
      echo_good_r <= echo_good_nxt;
      prev_byte_r <= rx_byte;
    end
  end

endmodule
`default_nettype wire

// ----- sv/binary_gnss_frame_checker.sv -----
// Top level of the binary frame checker: config registers, input and result registers.
//
//  channel  dir  handshake      payload
//  in_ch    in   valid/ready    rx_byte[7:0], end_of_buffer
//  out_ch   out  valid/ready    frame_status[1:0], sum_a[7:0], sum_b[7:0]
//  cfg_*    in   cfg_we only    cfg_index[2:0], cfg_data[7:0]
//
// One byte per cycle when not stalled: a byte is held in the input register, then the
// frame state and, on the last byte, the result register are updated.
// The result register captures a result as its last byte leaves the input register.
// Reset (rst_n low, synchronous) restores register defaults and clears frame state.
// Input stalls only while a last byte waits on an occupied, unread result register.
`default_nettype none
module binary_gnss_frame_checker (
  input  wire logic       clk,
  input  wire logic       rst_n,
  bgfc_in_if.sink         in_ch,
  bgfc_out_if.source      out_ch,
  input  wire logic       cfg_we,
  input  wire logic [2:0] cfg_index,
  input  wire logic [7:0] cfg_data
);

  bgfc_pkg::cfg_t    cfg_r;
  bgfc_pkg::result_t result;
  bgfc_pkg::result_t out_r;
  logic       out_valid_r;
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;
  logic       s1_adv;

  // Config register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cmd_class       <= '0;
      cfg_r.expected_msg_id <= '0;
      cfg_r.ack_mode        <= 1'b0;
      cfg_r.sync_first      <= bgfc_pkg::RST_SYNC_FIRST;
      cfg_r.sync_second     <= bgfc_pkg::RST_SYNC_SEC;
      cfg_r.ack_class       <= bgfc_pkg::RST_ACK_CLASS;
      cfg_r.ack_positive_id <= bgfc_pkg::RST_ACK_POS_ID;
      cfg_r.ack_negative_id <= bgfc_pkg::RST_ACK_NEG_ID;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bgfc_pkg::IDX_EXP_CLASS:  cfg_r.cmd_class       <= cfg_data;
        bgfc_pkg::IDX_EXP_MSG_ID: cfg_r.expected_msg_id <= cfg_data;
        bgfc_pkg::IDX_ACK_MODE:   cfg_r.ack_mode        <= cfg_data[0];
        bgfc_pkg::IDX_SYNC_FIRST: cfg_r.sync_first      <= cfg_data;
        bgfc_pkg::IDX_SYNC_SEC:   cfg_r.sync_second     <= cfg_data;
        bgfc_pkg::IDX_ACK_CLASS:  cfg_r.ack_class       <= cfg_data;
        bgfc_pkg::IDX_ACK_POS_ID: cfg_r.ack_positive_id <= cfg_data;
        bgfc_pkg::IDX_ACK_NEG_ID: cfg_r.ack_negative_id <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register moves on unless a last byte finds the result slot busy
  assign s1_adv      = s1_valid_r && (!s1_last_r || !out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_byte_r <= in_ch.rx_byte;
      s1_last_r <= in_ch.end_of_buffer;
    end
  end

  bgfc_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .step    (s1_adv),
    .rx_byte (s1_byte_r),
    .last    (s1_last_r),
    .result  (result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_last_r) begin
      out_r <= result;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.frame_status = out_r.frame_status;
  assign out_ch.sum_a        = out_r.sum_a;
  assign out_ch.sum_b        = out_r.sum_b;

endmodule
`default_nettype wire

// ----- sv/bgfc_checker.sv -----
// Port-level assertions for the binary frame checker, bound to the top level.
`default_nettype none
module bgfc_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [1:0] out_status,
  input wire logic [7:0] out_sum_a,
  input wire logic [7:0] out_sum_b
);

  // A stalled result word stays up
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  // A stalled result word keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      $stable(out_status) && $stable(out_sum_a) && $stable(out_sum_b))
    else $error("result payload changed while stalled");

  // Input back-pressure only comes from a full result register
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with result register empty");

  // Status never carries the unused code
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status != bgfc_pkg::ST_UNUSED)
    else $error("unused frame status code");

endmodule

bind binary_gnss_frame_checker bgfc_checker u_bgfc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_status (out_ch.frame_status),
  .out_sum_a  (out_ch.sum_a),
  .out_sum_b  (out_ch.sum_b)
);
`default_nettype wire
